>>> hdl/annexb_nal_splitter_classifier_macros.svh
// Assertion helpers for the checker file.
`ifndef ANNEXB_NAL_SPLITTER_CLASSIFIER_MACROS_SVH
`define ANNEXB_NAL_SPLITTER_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ANXB_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("anxb: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ANXB_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("anxb: next-cycle check failed");

`endif

>>> hdl/anxb_pkg.sv
package anxb_pkg;

  localparam int unsigned LengthBits  = 24;
  // tdata carries payload, length and 14 bits of header fields, padded to whole bytes
  localparam int unsigned SumBits     = LengthBits + 22;
  localparam int unsigned OutDataBits = ((SumBits + 7) / 8) * 8;

  localparam logic [LengthBits-1:0] LengthMax = {LengthBits{1'b1}};
  localparam logic [LengthBits-1:0] LengthOne = {{(LengthBits-1){1'b0}}, 1'b1};

  localparam logic [7:0] ZeroByte = 8'h00;
  localparam logic [7:0] OneByte  = 8'h01;

  localparam logic [2:0] PrefixShort = 3'd3;
  localparam logic [2:0] PrefixLong  = 3'd4;

  // NAL unit types of interest
  localparam logic [4:0] NalSlice = 5'd1;
  localparam logic [4:0] NalIdr   = 5'd5;
  localparam logic [4:0] NalSei   = 5'd6;
  localparam logic [4:0] NalSps   = 5'd7;
  localparam logic [4:0] NalPps   = 5'd8;

  // frame classes
  localparam logic [2:0] ClsNone = 3'd0;
  localparam logic [2:0] ClsP    = 3'd1;
  localparam logic [2:0] ClsB    = 3'd2;
  localparam logic [2:0] ClsI    = 3'd3;
  localparam logic [2:0] ClsSei  = 3'd4;
  localparam logic [2:0] ClsSps  = 3'd5;
  localparam logic [2:0] ClsPps  = 3'd6;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindSummary = 2'd1,
    KindError   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StWait   = 2'd0,
    StUnit   = 2'd1,
    StResync = 2'd2,
    StFlush  = 2'd3
  } state_e;

  typedef enum logic [1:0] {
    GpFirst = 2'd0,
    GpSlice = 2'd1,
    GpDone  = 2'd2,
    GpFail  = 2'd3
  } gphase_e;

  typedef struct packed {
    gphase_e     phase;
    logic [5:0]  zeros;
    logic [31:0] value;
    logic [5:0]  bits_left;
    logic [2:0]  cls;
  } gstate_t;

  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            payload;
    logic [LengthBits-1:0] unit_length;
    logic [2:0]            prefix_length;
    logic                  forbidden_flag;
    logic [1:0]            reference_idc;
    logic [4:0]            unit_type;
    logic [2:0]            frame_class;
    logic                  last_of_run;
  } res_t;

endpackage

>>> hdl/anxb_golomb.sv
// Runs the two-value Exp-Golomb reader over the eight bits of one byte, MSB first.
module anxb_golomb (
  input  anxb_pkg::gstate_t g_i,
  input  logic [7:0]        byte_i,
  output anxb_pkg::gstate_t g_o
);

  anxb_pkg::gstate_t g;
  logic              b_v;
  logic              done_f;
  logic [31:0]       done_val;

  function automatic logic [2:0] slice_class(input logic [31:0] v);
    case (v) inside
      32'd0, 32'd3, 32'd5, 32'd8:  slice_class = anxb_pkg::ClsP;
      32'd1, 32'd6:                slice_class = anxb_pkg::ClsB;
      32'd2, 32'd4, 32'd7, 32'd9:  slice_class = anxb_pkg::ClsI;
      default:                     slice_class = anxb_pkg::ClsNone;
    endcase
  endfunction

  always_comb begin
    g        = g_i;
    b_v      = 1'b0;
    done_f   = 1'b0;
    done_val = '0;
    for (int i = 7; i >= 0; i--) begin
      b_v      = byte_i[i];
      done_f   = 1'b0;
      done_val = '0;
      if (g.phase == anxb_pkg::GpFirst || g.phase == anxb_pkg::GpSlice) begin
        if (g.bits_left == '0) begin
          if (!b_v) begin
            g.zeros = g.zeros + 6'd1;
            if (g.zeros > 6'd31) begin
              g.phase = anxb_pkg::GpFail;
            end
          end else if (g.zeros == '0) begin
            done_f = 1'b1;
          end else begin
            g.bits_left = g.zeros;
            g.value     = 32'd1;
          end
        end else begin
          g.value     = {g.value[30:0], b_v};
          g.bits_left = g.bits_left - 6'd1;
          if (g.bits_left == '0) begin
            done_f   = 1'b1;
            done_val = g.value - 32'd1;
          end
        end
        if (done_f) begin
          if (g.phase == anxb_pkg::GpFirst) begin
            g.phase = anxb_pkg::GpSlice;
          end else begin
            g.cls   = slice_class(done_val);
            g.phase = anxb_pkg::GpDone;
          end
          g.zeros     = '0;
          g.value     = '0;
          g.bits_left = '0;
        end
      end
    end
  end

  assign g_o = g;

endmodule

>>> hdl/anxb_out_q.sv
// Two-entry result buffer; keeps the parser running while a result waits.
module anxb_out_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  anxb_pkg::res_t data_i,
  output logic           space_o,
  output logic           valid_o,
  input  logic           ready_i,
  output anxb_pkg::res_t data_o
);

  anxb_pkg::res_t mem_q [2];
  logic           wr_q, wr_d;
  logic           rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           pop;

  assign valid_o = (cnt_q != 2'd0);
  assign space_o = (cnt_q != 2'd2);
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> hdl/anxb_parse.sv
// Start-code tracker, lookahead window, unit counters and result formation.
module anxb_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [7:0]     in_byte_i,
  input  logic           in_eos_i,
  output logic           in_ready_o,
  input  logic           space_i,
  output logic           res_valid_o,
  output anxb_pkg::res_t res_o
);

  anxb_pkg::state_e                state_q, state_d;
  logic                            four_q, four_d;
  logic [3:0][7:0]                 la_q, la_d;
  logic [2:0]                      cnt_q, cnt_d;
  logic [anxb_pkg::LengthBits-1:0] bc_q, bc_d;
  logic [7:0]                      hdr_q, hdr_d;
  anxb_pkg::gstate_t               g_q, g_d, g_next;

  logic             fire, go, take;
  logic [3:0][7:0]  la_w;
  logic [2:0]       cnt_inc;
  logic             full, match;
  logic             st_open, st_four, st_summary, st_payload, st_error;
  anxb_pkg::state_e post_state;
  logic [2:0]       post_cnt;
  logic             post_bc_nz, more;
  logic             clear_unit, clear_all;
  anxb_pkg::res_t   sum_res, pay_res, err_res;

  function automatic logic [2:0] unit_class(input logic [7:0] hdr,
                                            input anxb_pkg::gstate_t g);
    logic [4:0] t;
    t = hdr[4:0];
    case (t) inside
      anxb_pkg::NalSlice, anxb_pkg::NalIdr:
        unit_class = (g.phase == anxb_pkg::GpDone) ? g.cls : anxb_pkg::ClsNone;
      anxb_pkg::NalSei: unit_class = anxb_pkg::ClsSei;
      anxb_pkg::NalSps: unit_class = anxb_pkg::ClsSps;
      anxb_pkg::NalPps: unit_class = anxb_pkg::ClsPps;
      default:          unit_class = anxb_pkg::ClsNone;
    endcase
  endfunction

  assign in_ready_o = (state_q != anxb_pkg::StFlush) && space_i;
  assign fire       = in_valid_i && in_ready_o;
  assign go         = fire || (state_q == anxb_pkg::StFlush && space_i);

  anxb_golomb u_golomb (
    .g_i    (g_q),
    .byte_i (la_q[0]),
    .g_o    (g_next)
  );

  // the outgoing payload byte is always the oldest lookahead entry
  always_comb begin
    sum_res                = '0;
    sum_res.kind           = anxb_pkg::KindSummary;
    sum_res.unit_length    = bc_q;
    sum_res.prefix_length  = four_q ? anxb_pkg::PrefixLong : anxb_pkg::PrefixShort;
    sum_res.forbidden_flag = hdr_q[7];
    sum_res.reference_idc  = hdr_q[6:5];
    sum_res.unit_type      = hdr_q[4:0];
    sum_res.frame_class    = unit_class(hdr_q, g_q);
    pay_res                = '0;
    pay_res.kind           = anxb_pkg::KindPayload;
    pay_res.payload        = la_q[0];
    err_res                = '0;
    err_res.kind           = anxb_pkg::KindError;
  end

  // effect of the incoming byte, before end-of-stream handling
  always_comb begin
    la_w                = la_q;
    la_w[cnt_q[1:0]]    = in_byte_i;
    cnt_inc             = cnt_q + 3'd1;
    full                = 1'b0;
    match               = 1'b0;
    st_open             = 1'b0;
    st_four             = 1'b0;
    st_summary          = 1'b0;
    st_payload          = 1'b0;
    st_error            = 1'b0;
    post_state          = state_q;
    post_cnt            = cnt_q;
    unique case (state_q)
      anxb_pkg::StUnit: begin
        if (four_q) begin
          full  = (cnt_inc == 3'd4);
          match = (la_w[0] == anxb_pkg::ZeroByte) && (la_w[1] == anxb_pkg::ZeroByte) &&
                  (la_w[2] == anxb_pkg::ZeroByte) && (la_w[3] == anxb_pkg::OneByte);
        end else begin
          full  = (cnt_inc >= 3'd3);
          match = (la_w[0] == anxb_pkg::ZeroByte) && (la_w[1] == anxb_pkg::ZeroByte) &&
                  (la_w[2] == anxb_pkg::OneByte);
        end
        if (full && match) begin
          st_summary = 1'b1;
          st_open    = 1'b1;
          st_four    = four_q;
          post_cnt   = 3'd0;
        end else if (full) begin
          st_payload = 1'b1;
          post_cnt   = four_q ? 3'd3 : 3'd2;
        end else begin
          post_cnt = cnt_inc;
        end
      end
      anxb_pkg::StResync: begin
        if (in_byte_i == anxb_pkg::ZeroByte) begin
          post_cnt = (cnt_q < 3'd3) ? cnt_inc : cnt_q;
        end else if (in_byte_i == anxb_pkg::OneByte && cnt_q >= 3'd2) begin
          st_open    = 1'b1;
          st_four    = (cnt_q >= 3'd3);
          post_state = anxb_pkg::StUnit;
          post_cnt   = 3'd0;
        end else begin
          post_cnt = 3'd0;
        end
      end
      anxb_pkg::StWait: begin
        if (in_byte_i == anxb_pkg::ZeroByte) begin
          if (cnt_q < 3'd3) begin
            post_cnt = cnt_inc;
          end else begin
            st_error   = 1'b1;
            post_state = anxb_pkg::StResync;
            post_cnt   = 3'd3;
          end
        end else if (in_byte_i == anxb_pkg::OneByte && cnt_q == 3'd2) begin
          st_open    = 1'b1;
          post_state = anxb_pkg::StUnit;
          post_cnt   = 3'd0;
        end else if (in_byte_i == anxb_pkg::OneByte && cnt_q == 3'd3) begin
          st_open    = 1'b1;
          st_four    = 1'b1;
          post_state = anxb_pkg::StUnit;
          post_cnt   = 3'd0;
        end else begin
          st_error   = 1'b1;
          post_state = anxb_pkg::StResync;
          post_cnt   = 3'd0;
        end
      end
      anxb_pkg::StFlush: begin
        post_state = anxb_pkg::StFlush;
      end
      default: begin
        post_state = state_q;
      end
    endcase
    post_bc_nz = !st_open && ((bc_q != '0) || st_payload);
    // end of stream inside a unit with lookahead bytes or a summary left to flush
    more = in_eos_i && (post_state == anxb_pkg::StUnit) &&
           ((post_cnt != 3'd0) || post_bc_nz);
  end

  // next state
  always_comb begin
    state_d = state_q;
    if (go) begin
      if (state_q == anxb_pkg::StFlush) begin
        state_d = (cnt_q == 3'd0) ? anxb_pkg::StWait : anxb_pkg::StFlush;
      end else if (in_eos_i) begin
        state_d = more ? anxb_pkg::StFlush : anxb_pkg::StWait;
      end else begin
        state_d = post_state;
      end
    end
  end

  // datapath and result
  always_comb begin
    four_d      = four_q;
    la_d        = la_q;
    cnt_d       = cnt_q;
    bc_d        = bc_q;
    hdr_d       = hdr_q;
    g_d         = g_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    clear_unit  = 1'b0;
    clear_all   = 1'b0;
    take        = go && ((state_q == anxb_pkg::StFlush) ? (cnt_q != 3'd0) : st_payload);

    if (take) begin
      if (bc_q == '0) begin
        hdr_d = la_q[0];
      end else if (hdr_q[4:0] == anxb_pkg::NalSlice || hdr_q[4:0] == anxb_pkg::NalIdr) begin
        g_d = g_next;
      end
      if (bc_q != anxb_pkg::LengthMax) begin
        bc_d = bc_q + anxb_pkg::LengthOne;
      end
    end

    if (go) begin
      if (state_q == anxb_pkg::StFlush) begin
        res_valid_o = 1'b1;
        if (cnt_q != 3'd0) begin
          res_o = pay_res;
          la_d  = {anxb_pkg::ZeroByte, la_q[3:1]};
          cnt_d = cnt_q - 3'd1;
        end else begin
          res_o             = sum_res;
          res_o.last_of_run = 1'b1;
          clear_all         = 1'b1;
        end
      end else begin
        cnt_d = post_cnt;
        if (state_q == anxb_pkg::StUnit) begin
          la_d = st_payload ? {anxb_pkg::ZeroByte, la_w[3:1]} : la_w;
        end
        if (st_summary || st_payload || st_error) begin
          res_valid_o       = 1'b1;
          res_o             = st_summary ? sum_res : (st_payload ? pay_res : err_res);
          res_o.last_of_run = !more;
        end else if (in_eos_i && post_state == anxb_pkg::StWait && post_cnt != 3'd0) begin
          // stream ended inside a partial start code
          res_valid_o       = 1'b1;
          res_o             = err_res;
          res_o.last_of_run = 1'b1;
        end
        if (st_open) begin
          four_d     = st_four;
          clear_unit = 1'b1;
        end
        if (in_eos_i && !more) begin
          clear_all = 1'b1;
        end
      end
    end

    if (clear_unit || clear_all) begin
      la_d  = '0;
      cnt_d = 3'd0;
      bc_d  = '0;
      hdr_d = '0;
      g_d   = '0;
    end
    if (clear_all) begin
      four_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= anxb_pkg::StWait;
      four_q  <= 1'b0;
      la_q    <= '0;
      cnt_q   <= 3'd0;
      bc_q    <= '0;
      hdr_q   <= '0;
      g_q     <= '0;
    end else begin
      state_q <= state_d;
      four_q  <= four_d;
      la_q    <= la_d;
      cnt_q   <= cnt_d;
      bc_q    <= bc_d;
      hdr_q   <= hdr_d;
      g_q     <= g_d;
    end
  end

endmodule

>>> hdl/annexb_nal_splitter_classifier.sv
// H.264 Annex B splitter: takes one stream byte per transfer and returns the unit
// payload bytes (delayed by up to four bytes of start-code lookahead), a summary at
// the end of every unit but an empty one cut off by tlast, and an error result for
// a missing start code. A byte is taken every cycle as long as the downstream side
// keeps up; results are formed in the cycle that takes their byte and registered in
// the result buffer. A byte with tlast inside an open unit stalls input while the
// lookahead bytes still held (up to three) and then the summary go out, since the
// lookahead flush and the Exp-Golomb slice reader advance one byte per cycle while
// the buffer has space. A two-entry result buffer sits between the parser and the master side.
module annexb_nal_splitter_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,  // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload, [31:8] unit_length, [34:32] prefix_length, [35] forbidden_flag,
  // [37:36] reference_idc, [42:38] unit_type, [45:43] frame_class, [47:46] zero
  output logic [anxb_pkg::OutDataBits-1:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // [1:0] kind
  output logic        m_axis_tlast   // last_of_run
);

  logic           space;
  logic           res_valid;
  anxb_pkg::res_t res;
  anxb_pkg::res_t out;

  anxb_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_eos_i    (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .space_i     (space),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  anxb_out_q u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out)
  );

  assign m_axis_tdata = anxb_pkg::OutDataBits'({out.frame_class, out.unit_type,
                                                out.reference_idc, out.forbidden_flag,
                                                out.prefix_length, out.unit_length,
                                                out.payload});
  assign m_axis_tuser = out.kind;
  assign m_axis_tlast = out.last_of_run;

endmodule

>>> hdl/anxb_check.sv
`include "annexb_nal_splitter_classifier_macros.svh"

module anxb_check (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [anxb_pkg::OutDataBits-1:0] m_axis_tdata,
  input logic [1:0]                       m_axis_tuser,
  input logic                             m_axis_tlast
);

  logic                             out_stall;
  logic [anxb_pkg::OutDataBits+2:0] out_word;
  logic                             is_sum, is_err, is_pay;
  logic [2:0]                       sum_prefix;
  logic                             sum_ok, err_ok, pay_ok;

  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_word   = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
  assign is_sum     = m_axis_tvalid && (m_axis_tuser == anxb_pkg::KindSummary);
  assign is_err     = m_axis_tvalid && (m_axis_tuser == anxb_pkg::KindError);
  assign is_pay     = m_axis_tvalid && (m_axis_tuser == anxb_pkg::KindPayload);
  assign sum_prefix = m_axis_tdata[anxb_pkg::LengthBits+8 +: 3];
  assign sum_ok     = (sum_prefix == anxb_pkg::PrefixShort) ||
                      (sum_prefix == anxb_pkg::PrefixLong);
  assign err_ok     = m_axis_tlast && (m_axis_tdata == '0);
  assign pay_ok     = ((m_axis_tdata >> 8) == '0);

  // a stalled transfer keeps its contents
  `ANXB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_word))

  // summaries carry a 3 or 4 byte prefix length
  `ANXB_ASSERT_IMPL(a_sum_prefix, clk_i, rst_ni, is_sum, sum_ok)

  // an error always closes the run of results for its byte and carries all-zero data
  `ANXB_ASSERT_IMPL(a_err_last, clk_i, rst_ni, is_err, err_ok)

  // payload transfers leave the summary fields clear
  `ANXB_ASSERT_IMPL(a_pay_clean, clk_i, rst_ni, is_pay, pay_ok)

endmodule

bind annexb_nal_splitter_classifier anxb_check u_anxb_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/sv/annexb_nal_splitter_classifier_test.sv
`timescale 1ns / 100ps

class anxb_scoreboard;
  anxb_pkg::state_e                phase;
  bit                              long_prefix;
  logic [7:0]                      window [4];
  int unsigned                     window_fill;
  logic [anxb_pkg::LengthBits-1:0] payload_count;
  logic [7:0]                      header;
  anxb_pkg::gphase_e               gp;
  int unsigned                     gp_zeros;
  logic [31:0]                     gp_value;
  int unsigned                     gp_left;
  logic [2:0]                      slice_cls;
  anxb_pkg::res_t                  expected_q[$];
  anxb_pkg::res_t                  step_q[$];
  int unsigned                     errors;

  function new();
    errors = 0;
    clear_unit(1'b0);
    phase = anxb_pkg::StWait;
  endfunction

  function void clear_unit(bit four);
    phase         = anxb_pkg::StUnit;
    long_prefix   = four;
    foreach (window[i]) window[i] = anxb_pkg::ZeroByte;
    window_fill   = 0;
    payload_count = '0;
    header        = anxb_pkg::ZeroByte;
    gp            = anxb_pkg::GpFirst;
    gp_zeros      = 0;
    gp_value      = '0;
    gp_left       = 0;
    slice_cls     = anxb_pkg::ClsNone;
  endfunction

  function logic [2:0] map_slice(logic [31:0] t);
    case (t)
      0, 3, 5, 8:    return anxb_pkg::ClsP;
      1, 6:          return anxb_pkg::ClsB;
      2, 4, 7, 9:    return anxb_pkg::ClsI;
      default:       return anxb_pkg::ClsNone;
    endcase
  endfunction

  function void finish_golomb(logic [31:0] v);
    if (gp == anxb_pkg::GpFirst) begin
      gp = anxb_pkg::GpSlice;
    end else begin
      slice_cls = map_slice(v);
      gp = anxb_pkg::GpDone;
    end
    gp_zeros = 0;
    gp_value = '0;
    gp_left  = 0;
  endfunction

  function void golomb_bit(bit b);
    if (gp == anxb_pkg::GpDone || gp == anxb_pkg::GpFail) return;
    if (gp_left == 0) begin
      if (!b) begin
        gp_zeros++;
        if (gp_zeros > 31) gp = anxb_pkg::GpFail;
      end else if (gp_zeros == 0) begin
        finish_golomb('0);
      end else begin
        gp_left  = gp_zeros;
        gp_value = 32'd1;
      end
      return;
    end
    gp_value = {gp_value[30:0], b};
    gp_left--;
    if (gp_left == 0) finish_golomb(gp_value - 32'd1);
  endfunction

  function void emit(anxb_pkg::kind_e k, logic [7:0] pay);
    anxb_pkg::res_t r;
    r = '0;
    r.kind = k;
    r.payload = pay;
    step_q.push_back(r);
  endfunction

  function void push_payload(logic [7:0] b);
    if (payload_count == '0) begin
      header = b;
    end else if (header[4:0] == anxb_pkg::NalSlice || header[4:0] == anxb_pkg::NalIdr) begin
      for (int i = 7; i >= 0; i--) golomb_bit(b[i]);
    end
    if (payload_count != anxb_pkg::LengthMax) payload_count++;
    emit(anxb_pkg::KindPayload, b);
  endfunction

  function void push_summary();
    anxb_pkg::res_t r;
    r = '0;
    r.kind           = anxb_pkg::KindSummary;
    r.unit_length    = payload_count;
    r.prefix_length  = long_prefix ? anxb_pkg::PrefixLong : anxb_pkg::PrefixShort;
    r.forbidden_flag = header[7];
    r.reference_idc  = header[6:5];
    r.unit_type      = header[4:0];
    case (header[4:0])
      anxb_pkg::NalSlice, anxb_pkg::NalIdr:
        r.frame_class = (gp == anxb_pkg::GpDone) ? slice_cls : anxb_pkg::ClsNone;
      anxb_pkg::NalSei: r.frame_class = anxb_pkg::ClsSei;
      anxb_pkg::NalSps: r.frame_class = anxb_pkg::ClsSps;
      anxb_pkg::NalPps: r.frame_class = anxb_pkg::ClsPps;
      default:          r.frame_class = anxb_pkg::ClsNone;
    endcase
    step_q.push_back(r);
  endfunction

  function void raise_error(int unsigned run);
    phase = anxb_pkg::StResync;
    window_fill = run;
    emit(anxb_pkg::KindError, anxb_pkg::ZeroByte);
  endfunction

  // one accepted stream byte; queues every result it causes
  function void note_byte(logic [7:0] b, bit eos);
    int unsigned plen;
    int unsigned cnt;
    bit hit;
    anxb_pkg::res_t r;
    step_q.delete();
    case (phase)
      anxb_pkg::StUnit: begin
        plen = long_prefix ? 4 : 3;
        window[window_fill & 3] = b;
        window_fill++;
        if (window_fill >= plen) begin
          hit = (window[plen-1] == anxb_pkg::OneByte);
          for (int i = 0; i + 1 < plen; i++)
            if (window[i] != anxb_pkg::ZeroByte) hit = 1'b0;
          if (hit) begin
            push_summary();
            clear_unit(long_prefix);
          end else begin
            push_payload(window[0]);
            for (int i = 0; i < 3; i++) window[i] = window[i+1];
            window[3] = anxb_pkg::ZeroByte;
            window_fill = plen - 1;
          end
        end
      end
      anxb_pkg::StResync: begin
        if (b == anxb_pkg::ZeroByte) begin
          if (window_fill < 3) window_fill++;
        end else if (b == anxb_pkg::OneByte && window_fill >= 2) begin
          clear_unit(window_fill >= 3);
        end else begin
          window_fill = 0;
        end
      end
      default: begin
        if (b == anxb_pkg::ZeroByte) begin
          if (window_fill < 3) window_fill++;
          else raise_error(3);
        end else if (b == anxb_pkg::OneByte && window_fill == 2) begin
          clear_unit(1'b0);
        end else if (b == anxb_pkg::OneByte && window_fill == 3) begin
          clear_unit(1'b1);
        end else begin
          raise_error(0);
        end
      end
    endcase

    if (eos) begin
      if (phase == anxb_pkg::StUnit) begin
        cnt = (window_fill > 3) ? 3 : window_fill;
        for (int i = 0; i < cnt; i++) push_payload(window[i]);
        if (payload_count != '0) push_summary();
      end else if (phase != anxb_pkg::StResync && window_fill > 0) begin
        emit(anxb_pkg::KindError, anxb_pkg::ZeroByte);
      end
      clear_unit(1'b0);
      phase = anxb_pkg::StWait;
    end

    foreach (step_q[i]) begin
      r = step_q[i];
      r.last_of_run = (i == step_q.size() - 1);
      expected_q.push_back(r);
    end
  endfunction

  function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function void check_result(logic [1:0] kind_bits,
                             logic [anxb_pkg::OutDataBits-1:0] data,
                             logic last);
    anxb_pkg::res_t want;
    bit ok;
    if (expected_q.size() == 0) begin
      $display("%0t: result with nothing expected, expected none, actual kind %0h data %0h",
               $time, kind_bits, data);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    ok  = field_ok("kind", want.kind, kind_bits);
    ok &= field_ok("payload", want.payload, data[7:0]);
    ok &= field_ok("unit_length", want.unit_length, data[8 +: anxb_pkg::LengthBits]);
    ok &= field_ok("prefix_length", want.prefix_length,
                   data[anxb_pkg::LengthBits + 8 +: 3]);
    ok &= field_ok("forbidden_flag", want.forbidden_flag, data[anxb_pkg::LengthBits + 11]);
    ok &= field_ok("reference_idc", want.reference_idc,
                   data[anxb_pkg::LengthBits + 12 +: 2]);
    ok &= field_ok("unit_type", want.unit_type, data[anxb_pkg::LengthBits + 14 +: 5]);
    ok &= field_ok("frame_class", want.frame_class, data[anxb_pkg::LengthBits + 19 +: 3]);
    ok &= field_ok("pad", '0, 32'(data >> (anxb_pkg::LengthBits + 22)));
    ok &= field_ok("last_of_run", want.last_of_run, last);
    if (!ok) errors++;
  endfunction
endclass

module annexb_nal_splitter_classifier_test;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 25;

  // bit 8 marks end of stream
  localparam logic [8:0] DirectedSeq [25] = '{
    9'h0ff,                                   // no start code, then resync
    9'h000, 9'h000, 9'h000, 9'h001,           // long prefix
    9'h065, 9'h088,                           // IDR slice, I class
    9'h000, 9'h000, 9'h000, 9'h001,
    9'h000, 9'h000, 9'h000, 9'h001,           // empty unit
    9'h1e8,                                   // PPS, forbidden bit, flushed by eos
    9'h000, 9'h000, 9'h001,                   // short prefix
    9'h041, 9'h000, 9'h000, 9'h000, 9'h000,   // slice with an overlong code
    9'h100
  };

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [7:0]                       s_axis_tdata = '0;
  logic                             s_axis_tlast = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [anxb_pkg::OutDataBits-1:0] m_axis_tdata;
  logic [1:0]                       m_axis_tuser;
  logic                             m_axis_tlast;

  anxb_scoreboard sb = new();
  int unsigned    send_idle_pct = 10;
  int unsigned    recv_idle_pct = 82;
  int unsigned    cycle_count = 0;
  logic [7:0]     stream_q[$];

  annexb_nal_splitter_classifier u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("annexb_nal_splitter_classifier_test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input bit eos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_byte(b, eos);
  endtask

  // hold the input side until every queued result has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  function automatic void push_start(bit four);
    if (four) stream_q.push_back(anxb_pkg::ZeroByte);
    stream_q.push_back(anxb_pkg::ZeroByte);
    stream_q.push_back(anxb_pkg::ZeroByte);
    stream_q.push_back(anxb_pkg::OneByte);
  endfunction

  function automatic logic [7:0] slice_lead();
    case ($urandom_range(5))
      0:       return 8'h88;  // first_mb 0, slice_type 7
      1:       return 8'ha0;  // slice_type 1
      2:       return 8'hb0;  // slice_type 2
      3:       return 8'h90;  // slice_type 3
      4:       return anxb_pkg::ZeroByte;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void build_stream();
    bit          four;
    int unsigned units;
    int unsigned body;
    logic [4:0]  nal;
    four  = $urandom_range(1);
    units = $urandom_range(3, 1);
    stream_q.delete();
    case ($urandom_range(11))
      0: stream_q.push_back(8'($urandom_range(255, 2)));
      1: repeat (4) stream_q.push_back(anxb_pkg::ZeroByte);
      2: begin  // stream ends inside a start code
        repeat ($urandom_range(3, 1)) stream_q.push_back(anxb_pkg::ZeroByte);
        return;
      end
      3: begin  // junk that is dropped while hunting for a start code
        stream_q.push_back(8'($urandom_range(255, 2)));
        repeat ($urandom_range(3)) stream_q.push_back(8'($urandom));
        return;
      end
      default: ;
    endcase
    for (int u = 0; u < units; u++) begin
      push_start(($urandom_range(9) == 0) ? !four : four);
      if ($urandom_range(7) == 0) continue;
      case ($urandom_range(7))
        0, 1:    nal = anxb_pkg::NalSlice;
        2, 3:    nal = anxb_pkg::NalIdr;
        4:       nal = anxb_pkg::NalSei;
        5:       nal = anxb_pkg::NalSps;
        6:       nal = anxb_pkg::NalPps;
        default: nal = 5'($urandom);
      endcase
      stream_q.push_back({1'($urandom_range(9) == 0), 2'($urandom), nal});
      body = $urandom_range(5);
      for (int j = 0; j < body; j++)
        stream_q.push_back((j == 0 && (nal == anxb_pkg::NalSlice || nal == anxb_pkg::NalIdr)) ?
                           slice_lead() : 8'($urandom));
    end
    if ($urandom_range(3) == 0) push_start(four);
  endfunction

  task automatic run_random(input int unsigned quota);
    int unsigned sent;
    sent = 0;
    while (sent < quota) begin
      build_stream();
      foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
      sent += stream_q.size();
      if ($urandom_range(3) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedSeq[i]) send_byte(DirectedSeq[i][7:0], DirectedSeq[i][8]);
    run_random(PhaseItems);

    send_idle_pct = 82;
    recv_idle_pct = 10;
    run_random(PhaseItems);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PhaseItems);

    repeat (20) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      $display("%0t: results never arrived, expected %0d more, actual 0",
               $time, sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("annexb_nal_splitter_classifier_test passed");
    else
      $display("annexb_nal_splitter_classifier_test failed");
    $finish;
  end

endmodule
